/* design/cads_pkg.sv */
// Shared types and constants for the calibrated ADC/DAC scaler.
// Used by cads_front, cads_queue, cads_back and the top level; depends on nothing.
package cads_pkg;

  localparam int unsigned NumRegs   = 6;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned CfgW      = 64;
  localparam int unsigned QuotW     = 32;
  localparam int unsigned DivisorW  = 16;
  localparam int unsigned DivStages = QuotW;
  localparam logic [14:0] CodeMax   = 15'd32767;
  localparam logic [CfgW-1:0] CalReset = 64'h2710_0000_7FFF_0000;
  localparam logic [RegIdxW-1:0] DacBase = 3'd4;

  // Operation codes carried by the op field.
  typedef enum logic [1:0] {
    OP_ADC_SCALE   = 2'd0,
    OP_DAC_SCALE   = 2'd1,
    OP_DAC_INVERSE = 2'd2,
    OP_INVALID     = 2'd3
  } op_e;

  // Values needed after the division.
  typedef struct packed {
    logic               err;       // bad op or bad DAC channel
    logic               zero;      // force a zero result
    logic signed [17:0] addend;    // added to the signed quotient
    logic [14:0]        top;       // upper clamp, already limited to CodeMax
  } side_t;

  // One item as handed from the front part to the back part.
  typedef struct packed {
    logic signed [35:0] prod;      // dividend
    logic signed [17:0] dvs;       // divisor, never zero
    side_t              side;
  } work_t;

endpackage

/* design/cads_front.sv */
// Front part: calibration registers, item decode and the dividend multiply.
// Depends on cads_pkg; feeds cads_queue.
module cads_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cads_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [cads_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         accept_i,
  input  logic [1:0]                   op_i,
  input  logic [1:0]                   channel_i,
  input  logic signed [15:0]           value_i,
  input  logic                         q_ready_i,
  output logic                         busy_o,
  output logic                         q_valid_o,
  output cads_pkg::work_t              q_data_o
);

  typedef cads_pkg::op_e op_e_t;

  logic [cads_pkg::CfgW-1:0] cal_q [cads_pkg::NumRegs];
  logic                      fv_q, fv_d;
  cads_pkg::work_t           work_q;

  logic [cads_pkg::RegIdxW-1:0] sel;
  logic [cads_pkg::CfgW-1:0]    word;
  logic signed [17:0]           lo, hi, off, fs, v, vpos, span, a, b, dvs, adj, voff;
  logic                         eq, fs_zero, err;
  logic signed [17:0]           addend;
  logic [15:0]                  top16;
  cads_pkg::work_t              work_d;

  // Calibration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cads_pkg::NumRegs; i++) cal_q[i] <= cads_pkg::CalReset;
    end else if (cfg_we_i && (cfg_idx_i < cads_pkg::RegIdxW'(cads_pkg::NumRegs))) begin
      cal_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Pick the channel word and unpack it.
  always_comb begin
    sel  = (op_e_t'(op_i) == cads_pkg::OP_ADC_SCALE) ? {1'b0, channel_i}
                                                     : cads_pkg::DacBase + {2'b0, channel_i[0]};
    word = cal_q[sel];
    lo   = 18'(signed'(word[15:0]));
    hi   = 18'(signed'(word[31:16]));
    off  = 18'(signed'(word[47:32]));
    fs   = $signed({2'b00, word[63:48]});
    v    = 18'(value_i);
    eq   = (lo == hi);
    fs_zero = (word[63:48] == 16'd0);
    span = hi - lo;
    vpos = value_i[15] ? 18'sd0 : v;
    err  = (op_e_t'(op_i) == cads_pkg::OP_INVALID) ||
           ((op_e_t'(op_i) != cads_pkg::OP_ADC_SCALE) && channel_i[1]);
    voff = v + off;
    if (voff < 0) adj = 18'sd0;
    else if (voff > fs) adj = fs;
    else adj = voff;
  end

  // Choose multiplicands, divisor and the post-division terms per operation.
  always_comb begin
    a      = 18'sd0;
    b      = 18'sd0;
    dvs    = 18'sd1;
    addend = 18'sd0;
    top16  = {1'b0, cads_pkg::CodeMax};
    unique case (op_e_t'(op_i))
      cads_pkg::OP_ADC_SCALE: begin
        a      = eq ? vpos : vpos - lo;
        b      = fs;
        dvs    = eq ? 18'sd32767 : span;
        addend = off;
        top16  = word[63:48];
      end
      cads_pkg::OP_DAC_SCALE: begin
        if (fs_zero) begin
          dvs = 18'sd1;
        end else if (eq) begin
          a   = adj;
          b   = 18'sd32767;
          dvs = fs;
        end else begin
          a      = v;
          b      = span;
          dvs    = fs;
          addend = lo + off;
        end
      end
      cads_pkg::OP_DAC_INVERSE: begin
        a      = eq ? v : v - lo;
        b      = fs;
        dvs    = eq ? 18'sd32767 : span;
        addend = -off;
        top16  = word[63:48];
      end
      default: begin
        dvs = 18'sd1;
      end
    endcase
    work_d.prod        = a * b;
    work_d.dvs         = dvs;
    work_d.side.err    = err;
    work_d.side.zero   = err || ((op_e_t'(op_i) == cads_pkg::OP_DAC_SCALE) && fs_zero);
    work_d.side.addend = addend;
    work_d.side.top    = (top16 > {1'b0, cads_pkg::CodeMax}) ? cads_pkg::CodeMax : top16[14:0];
  end

  // Holding register in front of the queue.
  assign busy_o = fv_q && !q_ready_i;
  assign fv_d   = accept_i || busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) work_q <= work_d;
  end

  assign q_valid_o = fv_q;
  assign q_data_o  = work_q;

endmodule

/* design/cads_queue.sv */
// Two-entry item queue between the front and back parts.
// Depends on cads_pkg for the work_t item type.
module cads_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cads_pkg::work_t push_data_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output cads_pkg::work_t pop_data_o
);

  cads_pkg::work_t mem_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;
  logic            do_push, do_pop;

  assign ready_o    = (cnt_q != 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

/* design/cads_back.sv */
// Back part: sign split, pipelined restoring divider, offset add and clamping.
// Depends on cads_pkg; takes items from cads_queue.
module cads_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  cads_pkg::work_t data_i,
  output logic            pop_o,
  output logic            result_valid_o,
  output logic [14:0]     result_o,
  output logic            channel_error_o
);

  localparam int unsigned NStg = cads_pkg::DivStages;
  localparam int unsigned QW   = cads_pkg::QuotW;
  localparam int unsigned DW   = cads_pkg::DivisorW;

  logic [NStg:0]   vld_q;
  logic [DW-1:0]   rem_q [NStg+1];
  logic [QW-1:0]   num_q [NStg+1];
  logic [DW-1:0]   dvs_q [NStg+1];
  logic            neg_q [NStg+1];
  cads_pkg::side_t side_q [NStg+1];

  logic            out_vld_q;
  logic [14:0]     res_q;
  logic            err_q;

  logic [35:0]     mag_p;
  logic [17:0]     mag_d;
  logic signed [33:0] quot;
  logic signed [34:0] sum;
  logic [14:0]     res_d;

  // The back part never stalls, so it drains the queue whenever it holds an item.
  assign pop_o = valid_i;

  always_comb begin
    mag_p = data_i.prod[35] ? 36'(-data_i.prod) : 36'(data_i.prod);
    mag_d = data_i.dvs[17] ? 18'(-data_i.dvs) : 18'(data_i.dvs);
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[NStg-1:0], valid_i};
      out_vld_q <= vld_q[NStg];
    end
  end

  // Divider stages: one quotient bit each.
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    num_q[0]  <= mag_p[QW-1:0];
    dvs_q[0]  <= mag_d[DW-1:0];
    neg_q[0]  <= data_i.prod[35] ^ data_i.dvs[17];
    side_q[0] <= data_i.side;
    for (int s = 0; s < NStg; s++) begin
      logic [DW:0] t;
      t = {rem_q[s], num_q[s][QW-1]};
      if (t >= {1'b0, dvs_q[s]}) begin
        rem_q[s+1] <= DW'(t - {1'b0, dvs_q[s]});
        num_q[s+1] <= {num_q[s][QW-2:0], 1'b1};
      end else begin
        rem_q[s+1] <= t[DW-1:0];
        num_q[s+1] <= {num_q[s][QW-2:0], 1'b0};
      end
      dvs_q[s+1]  <= dvs_q[s];
      neg_q[s+1]  <= neg_q[s];
      side_q[s+1] <= side_q[s];
    end
  end

  // Apply sign, add the offset term and clamp.
  always_comb begin
    quot = neg_q[NStg] ? -$signed({2'b00, num_q[NStg]}) : $signed({2'b00, num_q[NStg]});
    sum  = 35'(quot) + 35'(side_q[NStg].addend);
    if (side_q[NStg].zero || sum < 0) res_d = '0;
    else if (sum > $signed({20'd0, side_q[NStg].top})) res_d = side_q[NStg].top;
    else res_d = sum[14:0];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    err_q <= side_q[NStg].err;
  end

  assign result_valid_o  = out_vld_q;
  assign result_o        = res_q;
  assign channel_error_o = err_q;

  // Every item leaving the divider shows up as a result in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) vld_q[NStg] |=> result_valid_o)
    else $error("divider output lost");
  // A flagged item reports a zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && channel_error_o) |-> (result_o == 15'd0))
    else $error("error item with nonzero result");
  // Results appear only for items that entered the divider.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(vld_q[NStg]))
    else $error("spurious result");

endmodule

/* design/calibrated_adc_dac_scaler.sv */
// Top level of the calibrated ADC/DAC scaler.
// Depends on cads_pkg, cads_front, cads_queue and cads_back.
//
// Usage:
//   Configuration: cfg_we_i, cfg_idx_i and cfg_data_i write one 64-bit
//   calibration word per clock (indexes 0..3 ADC, 4..5 DAC); other indexes
//   are ignored. Write only while no item is in flight.
//   Input: an item (op_i, channel_i, value_i) is taken at a clock edge with
//   start_i high and busy_o low.
//   Output: each item yields one result on result_o/channel_error_o, valid
//   for exactly one cycle while result_valid_o is high, in input order.
//   Throughput: one item per cycle while busy_o is low. After the accepting
//   edge an item passes through the queue, the sign split stage, the
//   restoring divider stages (one quotient bit per stage) and the offset
//   and clamp stage, which raises result_valid_o. The front register loads
//   at the accepting edge itself.
//   Reset: clears all control state and loads every calibration word with
//   low 0, high 32767, offset 0, full scale 10000. The receiver cannot stall;
//   busy_o stays low in normal use.
module calibrated_adc_dac_scaler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cads_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [cads_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   op_i,
  input  logic [1:0]                   channel_i,
  input  logic signed [15:0]           value_i,
  output logic                         result_valid_o,
  output logic [14:0]                  result_o,
  output logic                         channel_error_o
);

  logic            f_valid, q_ready, q_valid, q_pop;
  cads_pkg::work_t f_data, q_data;

  cads_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (start_i && !busy_o),
    .op_i       (op_i),
    .channel_i  (channel_i),
    .value_i    (value_i),
    .q_ready_i  (q_ready),
    .busy_o     (busy_o),
    .q_valid_o  (f_valid),
    .q_data_o   (f_data)
  );

  cads_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_valid),
    .push_data_i (f_data),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  cads_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .data_i          (q_data),
    .pop_o           (q_pop),
    .result_valid_o  (result_valid_o),
    .result_o        (result_o),
    .channel_error_o (channel_error_o)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for the calibrated ADC/DAC scaler: a directed and a random item
// sequence across several calibration settings. Depends on cads_pkg and the RTL.
module tb_top;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [cads_pkg::RegIdxW-1:0] cfg_idx_i = '0;
  logic [cads_pkg::CfgW-1:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] op_i = '0;
  logic [1:0] channel_i = '0;
  logic signed [15:0] value_i = '0;
  logic result_valid_o;
  logic [14:0] result_o;
  logic channel_error_o;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] ch;
    logic signed [15:0] value;
  } conv_req_t;

  typedef struct packed {
    logic [14:0] code;
    logic err;
  } conv_res_t;

  logic [cads_pkg::CfgW-1:0] cal_words [cads_pkg::NumRegs];
  conv_req_t pending_reqs[$];
  conv_res_t expected_codes[$];
  int error_count = 0;
  int gap_left = 0;
  bit gaps_on = 1'b1;

  calibrated_adc_dac_scaler uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Predicts the converted code for one item from the current calibration.
  function automatic conv_res_t scale_item(conv_req_t rq);
    conv_res_t res;
    logic [cads_pkg::CfgW-1:0] word;
    longint v, lo, hi, off, fs, r, adj;
    res = '0;
    v = longint'(rq.value);
    if (cads_pkg::op_e'(rq.op) == cads_pkg::OP_INVALID ||
        (cads_pkg::op_e'(rq.op) != cads_pkg::OP_ADC_SCALE && rq.ch > 1)) begin
      res.err = 1'b1;
      return res;
    end
    word = (cads_pkg::op_e'(rq.op) == cads_pkg::OP_ADC_SCALE) ? cal_words[rq.ch]
                                                              : cal_words[cads_pkg::DacBase + rq.ch];
    lo = longint'($signed(word[15:0]));
    hi = longint'($signed(word[31:16]));
    off = longint'($signed(word[47:32]));
    fs = longint'({48'd0, word[63:48]});
    case (cads_pkg::op_e'(rq.op))
      cads_pkg::OP_ADC_SCALE: begin
        if (v < 0) v = 0;
        r = (hi == lo) ? v * fs / 32767 : (v - lo) * fs / (hi - lo);
        r = clamp_range(r + off, 0, fs);
      end
      cads_pkg::OP_DAC_SCALE: begin
        if (fs == 0) r = 0;
        else if (hi == lo) begin
          adj = clamp_range(v + off, 0, fs);
          r = adj * 32767 / fs;
        end else begin
          r = lo + v * (hi - lo) / fs;
          r = clamp_range(r + off, 0, 32767);
        end
      end
      default: begin
        r = (hi == lo) ? v * fs / 32767 : (v - lo) * fs / (hi - lo);
        r = clamp_range(r - off, 0, fs);
      end
    endcase
    res.code = 15'(clamp_range(r, 0, 32767));
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Driver: presents queued items, with random idle bursts.
  always @(posedge clk_i) begin
    if (rst_ni && !(start_i && busy_o)) begin
      if (start_i) expected_codes.push_back(scale_item({op_i, channel_i, value_i}));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        conv_req_t rq;
        rq = pending_reqs.pop_front();
        {op_i, channel_i, value_i} <= rq;
        start_i <= 1'b1;
        if (gaps_on && $urandom_range(0, 15) == 0) gap_left <= $urandom_range(1, 17);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: compares each result strobe against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_codes.size() == 0) begin
        report_mismatch("unexpected result", result_o, -1);
      end else begin
        conv_res_t want;
        want = expected_codes.pop_front();
        if (result_o !== want.code) report_mismatch("result", result_o, want.code);
        if (channel_error_o !== want.err) report_mismatch("channel_error", channel_error_o, want.err);
      end
    end
  end

  task automatic drain_items();
    while (pending_reqs.size() > 0 || start_i || expected_codes.size() > 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  // Writes one register; the caller drops the write enable after a batch.
  task automatic write_cal(int idx, logic [cads_pkg::CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx[cads_pkg::RegIdxW-1:0];
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx < cads_pkg::NumRegs) cal_words[idx] = data;
  endtask

  function automatic logic [cads_pkg::CfgW-1:0] rand_cal();
    logic [15:0] lo, hi;
    lo = 16'($urandom_range(0, 2000)) - 16'd500;
    hi = lo + 16'($urandom_range(1, 30000));
    case ($urandom_range(0, 4))
      0: return {$urandom(), $urandom()};
      1: return {16'($urandom_range(0, 32767)), 16'($urandom_range(0, 400)) - 16'd200, lo, lo};
      default: return {16'($urandom_range(1, 40000)), 16'($urandom_range(0, 400)) - 16'd200,
                       hi, lo};
    endcase
  endfunction

  function automatic conv_req_t rand_req();
    conv_req_t rq;
    rq.op = ($urandom_range(0, 19) == 0) ? 2'(cads_pkg::OP_INVALID) : 2'($urandom_range(0, 2));
    rq.ch = ($urandom_range(0, 9) == 0) ? 2'($urandom) :
            (rq.op == cads_pkg::OP_ADC_SCALE ? 2'($urandom_range(0, 3)) :
                                               2'($urandom_range(0, 1)));
    rq.value = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 12000));
    return rq;
  endfunction

  // Stimulus: reset, directed items, then random phases with new calibrations.
  initial begin
    for (int i = 0; i < cads_pkg::NumRegs; i++) cal_words[i] = cads_pkg::CalReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Reset calibration: field extremes, every op, bad channels and bad op.
    foreach (cal_words[i]) begin
      pending_reqs.push_back({2'(cads_pkg::OP_ADC_SCALE), 2'(i % 4), 16'sh7FFF});
    end
    pending_reqs.push_back({2'(cads_pkg::OP_ADC_SCALE), 2'd1, 16'sh8000});
    pending_reqs.push_back({2'(cads_pkg::OP_ADC_SCALE), 2'd2, 16'sd0});
    pending_reqs.push_back({2'(cads_pkg::OP_DAC_SCALE), 2'd0, 16'sd10000});
    pending_reqs.push_back({2'(cads_pkg::OP_DAC_SCALE), 2'd1, 16'sh8000});
    pending_reqs.push_back({2'(cads_pkg::OP_DAC_SCALE), 2'd2, 16'sd5});
    pending_reqs.push_back({2'(cads_pkg::OP_DAC_INVERSE), 2'd1, 16'sh7FFF});
    pending_reqs.push_back({2'(cads_pkg::OP_DAC_INVERSE), 2'd0, 16'sh8000});
    pending_reqs.push_back({2'(cads_pkg::OP_DAC_INVERSE), 2'd3, 16'sd5});
    pending_reqs.push_back({2'(cads_pkg::OP_INVALID), 2'd0, 16'sd100});
    pending_reqs.push_back({2'(cads_pkg::OP_INVALID), 2'd3, 16'shFFFF});
    drain_items();
    // Equal points, zero full scale, full scale above the code range, ignored index.
    write_cal(0, {16'hFFFF, 16'h8000, 16'h0100, 16'h0100});
    write_cal(1, {16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_cal(4, {16'h0000, 16'h0010, 16'h1000, 16'h0000});
    write_cal(5, {16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000});
    write_cal(2, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
    write_cal(3, {16'h9000, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_cal(6, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(7, 64'h0);
    cfg_we_i <= 1'b0;
    foreach (cal_words[i]) begin
      pending_reqs.push_back({2'(cads_pkg::OP_ADC_SCALE), 2'(i % 4), 16'sh7FFF});
      pending_reqs.push_back({2'(cads_pkg::OP_DAC_SCALE), 2'(i % 2), 16'sh7FFF});
      pending_reqs.push_back({2'(cads_pkg::OP_DAC_INVERSE), 2'(i % 2), 16'sh8000});
    end
    drain_items();
    // Random phases; the sender pauses for a full drain between them.
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < cads_pkg::NumRegs; i++) write_cal(i, rand_cal());
      cfg_we_i <= 1'b0;
      if (ph == 7) gaps_on = 1'b0;
      for (int n = 0; n < 50; n++) pending_reqs.push_back(rand_req());
      drain_items();
    end
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

/* calibrated_adc_dac_scaler.f */
design/cads_pkg.sv
design/cads_front.sv
design/cads_queue.sv
design/cads_back.sv
design/calibrated_adc_dac_scaler.sv
bench/tb_top.sv
